// ===== rtl/rail_fence_cipher_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the rail fence cipher RTL.
// Each macro expects i_clk and i_rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef RAIL_FENCE_CIPHER_MACROS_SVH
`define RAIL_FENCE_CIPHER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define RFC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rfc_pkg.sv =====
// ---------------------------------------------------------------------------
// rfc_pkg
// Types and constants shared by the rail fence cipher modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

    // Input queue between the front and the back end
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Widths that cover the whole supported buffer range (up to 64 bytes)
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    // Character constants
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    // Configuration registers
    localparam int              RAILS_W     = 5;
    localparam logic [4:0]      RAILS_RESET = 5'd2;
    localparam int              APB_AW      = 3;
    localparam logic            REG_RAILS   = 1'b0;
    localparam logic            REG_MODE    = 1'b1;
    localparam logic            MODE_ENC    = 1'b0;
    localparam logic            MODE_DEC    = 1'b1;

    // One classified character on its way to the back end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       keep;   // 0: buffer full, character dropped
    } t_item;

    // Write port into the output buffer
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

    // Hand-off of a permuted message to the emitter
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] len;
        logic             ovf;
    } t_start;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            r = c - CH_LOWER_A + CH_UPPER_A;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rfc_front.sv =====
// ---------------------------------------------------------------------------
// rfc_front
// Accepts characters, folds lower case to upper case and marks characters
// that no longer fit in the message buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfc_front
    import rfc_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_q_valid,
    input  wire logic       i_q_ready,
    output t_item           o_q_item
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          w_keep;
    logic          w_acc;

    assign w_keep     = (r_cnt < CW'(MAX_LEN));
    assign w_acc      = i_in_valid && i_q_ready;
    assign o_in_ready = i_q_ready;
    assign o_q_valid  = i_in_valid;

    always_comb begin
        o_q_item.data = to_upper(i_in_byte);
        o_q_item.last = i_in_last;
        o_q_item.keep = w_keep;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_acc) begin
            if (i_in_last) begin
                n_cnt = '0;
            end else if (w_keep) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rfc_fifo.sv =====
// ---------------------------------------------------------------------------
// rfc_fifo
// Short queue of classified characters between the front and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rail_fence_cipher_macros.svh"

module rfc_fifo
    import rfc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_item      o_item
);

    t_item           r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QAW:0]    r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready = (r_count != (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `RFC_ASSERT_ALWAYS(a_q_count_bound, r_count <= (QAW+1)'(QDEPTH), "queue count overran")
    `RFC_ASSERT_ALWAYS(a_q_ptr_gap, r_wp == QAW'(r_rp + r_count[QAW-1:0]), "queue pointers skew")

endmodule

`default_nettype wire

// ===== rtl/rfc_perm.sv =====
// ---------------------------------------------------------------------------
// rfc_perm
// Loads a message into the buffer, then walks the zigzag rail by rail and
// moves each character into the output buffer at its permuted place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rail_fence_cipher_macros.svh"

module rfc_perm
    import rfc_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int MAX_RAILS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire t_item              i_q_item,
    output logic                    o_q_pop,
    input  wire logic [RAILS_W-1:0] i_rails,
    input  wire logic               i_mode,
    input  wire logic               i_emit_idle,
    output t_wr                     o_wr,
    output t_start                  o_start
);

    localparam int PW   = $clog2(MAX_LEN);
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int KMAX = (MAX_RAILS < 31) ? MAX_RAILS : 31;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int SUMW = $clog2(MAX_LEN + 2 * KMAX + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_WAIT,
        S_PERM,
        S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_len, n_len;
    logic            r_ovf, n_ovf;
    logic [KW-1:0]   r_rail, n_rail;
    logic [PW-1:0]   r_pos, n_pos;
    logic            r_phase, n_phase;
    logic [CW-1:0]   r_i, n_i;
    logic            r_wv, n_wv;
    logic [PW-1:0]   r_wa, n_wa;
    logic            r_start, n_start;
    logic [CW-1:0]   r_slen, n_slen;
    logic            r_sovf, n_sovf;

    logic [7:0]      r_buf [MAX_LEN];
    logic [7:0]      r_bdata;

    logic [RAILS_W-1:0] w_rsat;
    logic [KW-1:0]      w_k;
    logic [KW-1:0]      w_dist;
    logic [SUMW-1:0]    w_a;
    logic [SUMW-1:0]    w_b;
    logic [SUMW-1:0]    w_step;
    logic [SUMW-1:0]    w_next;
    logic [SUMW-1:0]    w_rail_next;
    logic               w_issue;
    logic [PW-1:0]      w_raddr;

    // Rails of zero count as one; clamp to the largest fence supported
    always_comb begin
        if (i_rails == '0) begin
            w_rsat = RAILS_W'(1);
        end else if (i_rails > RAILS_W'(KMAX)) begin
            w_rsat = RAILS_W'(KMAX);
        end else begin
            w_rsat = i_rails;
        end
    end
    assign w_k = KW'(w_rsat);

    // Within a rail the gap alternates between the down and up legs
    always_comb begin
        w_dist = w_k - KW'(1) - r_rail;
        w_a    = SUMW'(w_dist) << 1;
        w_b    = SUMW'(r_rail) << 1;
        w_step = r_phase ? w_b : w_a;
        if (w_step == '0) begin
            w_step = r_phase ? w_a : w_b;
        end
        if (w_step == '0) begin
            w_step = SUMW'(1);
        end
        w_next      = SUMW'(r_pos) + w_step;
        w_rail_next = SUMW'(r_rail) + SUMW'(1);
    end

    assign o_q_pop = (r_state == S_LOAD) && i_q_valid;
    assign w_issue = (r_state == S_PERM) && (r_i != r_len);
    assign w_raddr = (i_mode == MODE_DEC) ? r_i[PW-1:0] : r_pos;

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_rail  = r_rail;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_i     = r_i;
        n_wv    = 1'b0;
        n_wa    = r_wa;
        n_start = 1'b0;
        n_slen  = r_slen;
        n_sovf  = r_sovf;
        case (r_state)
            S_LOAD: begin
                if (i_q_valid) begin
                    if (i_q_item.keep) begin
                        n_len = r_len + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_q_item.last) begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                // hold until the emitter has read out the previous message
                if (i_emit_idle) begin
                    n_state = S_PERM;
                    n_rail  = '0;
                    n_pos   = '0;
                    n_phase = 1'b0;
                    n_i     = '0;
                end
            end
            S_PERM: begin
                if (r_i == r_len) begin
                    n_state = S_FIN;
                end else begin
                    n_wv = 1'b1;
                    n_wa = (i_mode == MODE_DEC) ? r_pos : r_i[PW-1:0];
                    n_i  = r_i + 1'b1;
                    if (w_next >= SUMW'(r_len)) begin
                        n_rail  = r_rail + 1'b1;
                        n_pos   = PW'(w_rail_next);
                        n_phase = 1'b0;
                    end else begin
                        n_pos   = w_next[PW-1:0];
                        n_phase = !r_phase;
                    end
                end
            end
            S_FIN: begin
                n_start = 1'b1;
                n_slen  = r_len;
                n_sovf  = r_ovf;
                n_len   = '0;
                n_ovf   = 1'b0;
                n_state = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_wv    <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_wv    <= n_wv;
            r_start <= n_start;
        end
        r_rail  <= n_rail;
        r_pos   <= n_pos;
        r_phase <= n_phase;
        r_wa    <= n_wa;
        r_slen  <= n_slen;
        r_sovf  <= n_sovf;
    end

    // Message buffer: written while loading, read while permuting
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.keep) begin
            r_buf[r_len[PW-1:0]] <= i_q_item.data;
        end
        if (w_issue) begin
            r_bdata <= r_buf[w_raddr];
        end
    end

    always_comb begin
        o_wr.en       = r_wv;
        o_wr.addr     = IDX_W'(r_wa);
        o_wr.data     = r_bdata;
        o_start.valid = r_start;
        o_start.len   = CNT_W'(r_slen);
        o_start.ovf   = r_sovf;
    end

    `RFC_ASSERT_IMP(a_perm_wr_in_msg, r_wv, CW'(r_wa) < r_len, "write outside message")
    `RFC_ASSERT_IMP(a_perm_start_len, r_start, r_slen != '0, "empty message to emitter")
    `RFC_ASSERT_NEXT(a_perm_fin_clears, r_state == S_FIN, r_len == '0 && !r_ovf, "length kept")

endmodule

`default_nettype wire

// ===== rtl/rfc_emit.sv =====
// ---------------------------------------------------------------------------
// rfc_emit
// Holds the permuted message and streams it out in order, one character a
// cycle while the receiver is ready, through a read stage and an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rail_fence_cipher_macros.svh"

module rfc_emit
    import rfc_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_wr    i_wr,
    input  wire t_start i_start,
    output logic        o_idle,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_overflow
);

    localparam int PW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [7:0]    r_obuf [MAX_LEN];
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_j;
    logic          r_ovf;
    logic          r_dv;
    logic [7:0]    r_rd_byte;
    logic          r_rd_last;
    logic          r_rd_ovf;
    logic          r_ov;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_ovf;
    logic          w_move;
    logic          w_rd;

    assign o_idle = (r_j == r_n);
    assign w_move = r_dv && (!r_ov || i_out_ready);
    assign w_rd   = (r_j != r_n) && (!r_dv || w_move);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_obuf[i_wr.addr[PW-1:0]] <= i_wr.data;
        end
        if (w_rd) begin
            r_rd_byte <= r_obuf[r_j[PW-1:0]];
            r_rd_last <= ((r_j + 1'b1) == r_n);
            r_rd_ovf  <= r_ovf;
        end
        if (w_move) begin
            r_out_byte <= r_rd_byte;
            r_out_last <= r_rd_last;
            r_out_ovf  <= r_rd_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_j   <= '0;
            r_ovf <= 1'b0;
            r_dv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_start.valid) begin
                r_n   <= i_start.len[CW-1:0];
                r_j   <= '0;
                r_ovf <= i_start.ovf;
            end else if (w_rd) begin
                r_j <= r_j + 1'b1;
            end
            if (w_rd) begin
                r_dv <= 1'b1;
            end else if (w_move) begin
                r_dv <= 1'b0;
            end
            if (w_move) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_overflow  = r_out_ovf;

    `RFC_ASSERT_ALWAYS(a_emit_idx_bound, r_j <= r_n, "read index ran past message")
    `RFC_ASSERT_IMP(a_emit_start_idle, i_start.valid, r_j == r_n, "new message while still reading")

endmodule

`default_nettype wire

// ===== rtl/rail_fence_cipher.sv =====
// ---------------------------------------------------------------------------
// rail_fence_cipher
// Rail fence encrypt/decrypt of byte messages with upper-case folding.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_ready    i_in_byte, i_in_last
//   out      source     o_out_valid / i_out_ready  o_out_byte, o_out_last, o_overflow
//   config   APB slave  psel/penable/pready        paddr, pwdata, prdata
//
// Characters enter at one per cycle through a four-entry queue. A message is
// then permuted through the single-port message buffer and handed off, and
// streams out at one byte per cycle while the next message loads.
// Reset is synchronous; no clearing pass. A stalled output holds the emitter,
// and a full queue holds the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rail_fence_cipher
    import rfc_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int MAX_RAILS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_in_last,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_out_last,
    output logic                   o_overflow,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [RAILS_W-1:0] r_rails;
    logic               r_mode;
    logic               w_cfg_wr;
    logic               w_reg_idx;

    logic   w_fq_valid;
    logic   w_fq_ready;
    t_item  w_fq_item;
    logic   w_q_valid;
    logic   w_q_pop;
    t_item  w_q_item;
    t_wr    w_wr;
    t_start w_start;
    logic   w_emit_idle;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rails <= RAILS_RESET;
            r_mode  <= MODE_ENC;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_RAILS: r_rails <= pwdata[RAILS_W-1:0];
                REG_MODE:  r_mode  <= pwdata[0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_RAILS: prdata = {{(32-RAILS_W){1'b0}}, r_rails};
            REG_MODE:  prdata = {31'd0, r_mode};
            default:   prdata = '0;
        endcase
    end

    rfc_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_q_valid  (w_fq_valid),
        .i_q_ready  (w_fq_ready),
        .o_q_item   (w_fq_item)
    );

    rfc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_valid),
        .i_item  (w_fq_item),
        .o_ready (w_fq_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    rfc_perm #(
        .MAX_LEN   (MAX_LEN),
        .MAX_RAILS (MAX_RAILS)
    ) u_perm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .i_rails     (r_rails),
        .i_mode      (r_mode),
        .i_emit_idle (w_emit_idle),
        .o_wr        (w_wr),
        .o_start     (w_start)
    );

    rfc_emit #(
        .MAX_LEN (MAX_LEN)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_start     (w_start),
        .o_idle      (w_emit_idle),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_overflow  (o_overflow)
    );

endmodule

`default_nettype wire

// ===== bench/rfc_stream_checker.sv =====
// ---------------------------------------------------------------------------
// rfc_stream_checker
// Watches the configuration port and both streams of the rail fence block.
// Mirrors the fence settings, collects each message as it loads, works out
// the permuted characters when the last byte arrives and compares every
// output transaction with the oldest expected character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfc_stream_checker
    import rfc_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int MAX_RAILS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [7:0]        i_out_byte,
    input  logic              i_out_last,
    input  logic              i_overflow,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } t_exp_char;

    logic [7:0]   msg_buf [MAX_LEN];
    int unsigned  msg_len;
    logic         dropped;
    logic [4:0]   rails_cfg;
    logic         mode_cfg;
    t_exp_char    expected_chars[$];
    int           mismatches;
    int           checked;

    function automatic int unsigned rail_index(input int unsigned pos, input int unsigned k);
        int unsigned period;
        int unsigned m;
        if (k <= 1) begin
            return 0;
        end
        period = 2 * (k - 1);
        m = pos % period;
        return (m < k) ? m : (period - m);
    endfunction

    // Queue the permuted message, then clear the load state for the next one
    task automatic push_permutation();
        int unsigned  n;
        int unsigned  k;
        int unsigned  cnt;
        int unsigned  order [MAX_LEN];
        logic [7:0]   perm [MAX_LEN];
        t_exp_char    c;
        n = msg_len;
        k = int'(rails_cfg);
        if (k == 0) begin
            k = 1;
        end
        if (k > MAX_RAILS) begin
            k = MAX_RAILS;
        end
        cnt = 0;
        for (int unsigned r = 0; r < k; r++) begin
            for (int unsigned p = 0; p < n; p++) begin
                if (rail_index(p, k) == r) begin
                    order[cnt] = p;
                    cnt++;
                end
            end
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (mode_cfg == MODE_ENC) begin
                perm[i] = msg_buf[order[i]];
            end else begin
                perm[order[i]] = msg_buf[i];
            end
        end
        for (int unsigned i = 0; i < n; i++) begin
            c.data = perm[i];
            c.last = (i + 1 == n);
            c.ovf  = dropped;
            expected_chars = {expected_chars, c};
        end
        msg_len = 0;
        dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_exp_char    want;
        logic [7:0]   ch;
        if (!i_rst_n) begin
            msg_len   = 0;
            dropped   = 1'b0;
            rails_cfg = RAILS_RESET;
            mode_cfg  = MODE_ENC;
            expected_chars.delete();
            mismatches = 0;
            checked    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[APB_AW-1:2] == REG_RAILS) begin
                    rails_cfg = pwdata[RAILS_W-1:0];
                end else if (paddr[APB_AW-1:2] == REG_MODE) begin
                    mode_cfg = pwdata[0];
                end
            end
            // Older message first: results never leave in the cycle their last byte enters
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] unexpected output: byte %02h last %0b ovf %0b",
                                 $realtime, i_out_byte, i_out_last, i_overflow);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    checked++;
                    if (want.data !== i_out_byte || want.last !== i_out_last ||
                        want.ovf !== i_overflow) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] output %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     $realtime, checked, want.data, want.last, want.ovf,
                                     i_out_byte, i_out_last, i_overflow);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                ch = i_in_byte;
                if (ch >= 8'h61 && ch <= 8'h7A) begin
                    ch = ch - 8'h20;
                end
                if (msg_len < MAX_LEN) begin
                    msg_buf[msg_len] = ch;
                    msg_len++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_in_last) begin
                    push_permutation();
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_chars.size();
        o_checked <= checked;
    end

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the rail fence cipher block. Runs a directed set
// of messages across boundary bytes and fence settings, then random messages
// over random settings, including a full buffer and a truncated message,
// with random gaps on the sender and stalls on the receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rfc_pkg::*;

    localparam int MAX_LEN    = 64;
    localparam int MAX_RAILS  = 16;
    localparam int LIMIT      = 200000;
    localparam int DRAIN      = 40;
    localparam int RAND_BYTES = 85;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_in_byte;
    logic              i_in_last;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [7:0]        o_out_byte;
    logic              o_out_last;
    logic              o_overflow;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int          errors;
    int          pending;
    int          checked;
    int          cycles;
    bit          in_gaps;
    bit          out_stalls;
    logic [7:0]  msg_q[$];
    int          n_msgs;
    int          n_bytes;
    int          n_settings;
    int          n_truncated;
    int          rand_bytes;
    int          phase;

    rail_fence_cipher #(
        .MAX_LEN   (MAX_LEN),
        .MAX_RAILS (MAX_RAILS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_overflow  (o_overflow),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    rfc_stream_checker #(
        .MAX_LEN   (MAX_LEN),
        .MAX_RAILS (MAX_RAILS)
    ) fence_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_byte  (o_out_byte),
        .i_out_last  (o_out_last),
        .i_overflow  (o_overflow),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: stall in random bursts while enabled
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (out_stalls && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    task automatic cfg_write(input logic reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Upper data bits are noise; the block keeps only the register width
    task automatic set_fence(input logic [4:0] rails, input logic mode);
        cfg_write(REG_RAILS, ($urandom & 32'hFFFF_FFE0) | {27'd0, rails});
        cfg_write(REG_MODE, ($urandom & 32'hFFFF_FFFE) | {31'd0, mode});
        n_settings++;
    endtask

    // Hold the sender until every expected character is out, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        if (in_gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        i_in_last  = last;
        do @(posedge i_clk); while (!o_in_ready);
        n_bytes++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++) begin
            send_byte(msg_q[i], i == msg_q.size() - 1);
        end
        if (msg_q.size() > MAX_LEN) begin
            n_truncated++;
        end
        n_msgs++;
        msg_q.delete();
    endtask

    // Mostly letters of either case, some arbitrary bytes
    task automatic fill_message(input int len);
        int pick;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 3);
            if (pick <= 1) begin
                msg_q = {msg_q, 8'h61 + 8'($urandom_range(0, 25))};
            end else if (pick == 2) begin
                msg_q = {msg_q, 8'h41 + 8'($urandom_range(0, 25))};
            end else begin
                msg_q = {msg_q, 8'($urandom_range(0, 255))};
            end
        end
    endtask

    function automatic logic [4:0] pick_rails();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 5'd0;
        end else if (pick == 1) begin
            return 5'($urandom_range(MAX_RAILS + 1, 31));
        end else if (pick == 2) begin
            return 5'(MAX_RAILS);
        end
        return 5'($urandom_range(1, MAX_RAILS));
    endfunction

    initial begin
        int len;
        cycles      = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_in_last   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_gaps     = 1'b1;
        out_stalls  = 1'b1;
        n_msgs      = 0;
        n_bytes     = 0;
        n_settings  = 0;
        n_truncated = 0;
        rand_bytes  = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: two rails, encrypt; case-folding boundaries and byte extremes
        msg_q = {8'h61, 8'h7A, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h41};
        send_message();
        msg_q = {msg_q, 8'h80};
        send_message();
        drain();
        set_fence(5'd3, MODE_DEC);
        fill_message(6);
        send_message();
        drain();
        set_fence(5'd1, MODE_ENC);
        fill_message(3);
        send_message();
        drain();
        set_fence(5'd0, MODE_DEC);
        fill_message(2);
        send_message();
        drain();
        // Rails at or beyond the length, then above the supported maximum
        set_fence(5'(MAX_RAILS), MODE_ENC);
        fill_message(4);
        send_message();
        drain();
        set_fence(5'd31, MODE_DEC);
        fill_message(2);
        send_message();

        phase = 0;
        while (rand_bytes < RAND_BYTES) begin
            drain();
            if (rand_bytes >= RAND_BYTES - 25) begin
                in_gaps    = 1'b0;
                out_stalls = 1'b0;
            end else begin
                in_gaps    = $urandom_range(0, 2) != 0;
                out_stalls = $urandom_range(0, 2) != 0;
            end
            set_fence(pick_rails(), 1'($urandom_range(0, 1)));
            if (phase == 0) begin
                // Fill the buffer, then drop a byte or two past the end
                len = $urandom_range(MAX_LEN + 1, MAX_LEN + 2);
                fill_message(len);
                rand_bytes += len;
                send_message();
            end else begin
                repeat ($urandom_range(2, 4)) begin
                    if (rand_bytes < RAND_BYTES) begin
                        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(1, 12);
                        fill_message(len);
                        rand_bytes += len;
                        send_message();
                    end
                end
            end
            phase++;
        end
        drain();

        $display("Sent %0d messages (%0d bytes, %0d truncated) over %0d fence settings",
                 n_msgs, n_bytes, n_truncated, n_settings);
        $display("Checked %0d output characters, %0d mismatches, %0d never delivered",
                 checked, errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
